[rtl/core/catmull_rom_spline_eval_macros.svh]
// ---------------------------------------------------------------------------
// Catmull-Rom evaluator assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef CATMULL_ROM_SPLINE_EVAL_MACROS_SVH
`define CATMULL_ROM_SPLINE_EVAL_MACROS_SVH
// implication checked on every clock, quiet in reset
`define CRS_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("check failed");
// next-cycle implication
`define CRS_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("check failed");
`endif

[rtl/core/crse_pkg.sv]
// ---------------------------------------------------------------------------
// Catmull-Rom evaluator package
// Payload word types, command codes and default sizes.
// ---------------------------------------------------------------------------
package crse_pkg;
	localparam int MAX_POINTS_DEF = 16;
	localparam int COORD_BITS_DEF = 32;
	localparam int COORD_BITS = 32;
	localparam int CNT_BITS = 5;
	localparam int PARAM_BITS = 17;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                          command;
		logic [3:0]                    point_slot;
		logic signed [COORD_BITS-1:0]  point_x;
		logic signed [COORD_BITS-1:0]  point_y;
		logic signed [COORD_BITS-1:0]  point_z;
		logic [PARAM_BITS-1:0]         curve_param;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
	} out_word_t;
endpackage

[rtl/core/catmull_rom_spline_eval.sv]
// ---------------------------------------------------------------------------
// Catmull-Rom spline evaluator
// Stores 3D control points and evaluates a uniform Catmull-Rom curve.
// ---------------------------------------------------------------------------
//  channel  | signals                        | accepted when
//  in       | in_valid, in_stall, in_word    | in_valid && !in_stall
//  out      | out_valid, out_stall, out_word | out_valid && !out_stall
//  cfg      | cfg_we, cfg_data               | cfg_we
// One word per cycle unless stalled. An evaluate passes the scale, read and
// coefficient stages, three Horner multiply steps (each a multiply stage and
// a round/add stage) and the output register. Writes take effect in the store when accepted.
// arst_n clears valid bits and point_count (to 4); the store is undefined.
// A stall freezes the whole pipe; in_stall is high while a result waits under out_stall.
module catmull_rom_spline_eval #(
	parameter int MAX_POINTS = crse_pkg::MAX_POINTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  crse_pkg::in_word_t         in_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output crse_pkg::out_word_t        out_word,
	input  logic                       cfg_we,
	input  logic [crse_pkg::CNT_BITS-1:0] cfg_data
);
	import crse_pkg::*;

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CB = COORD_BITS;
	localparam int EW = CB + 5;
	localparam int AW = CB + 8;
	localparam int SW = PARAM_BITS + 9;
	localparam int NS = 10;

	logic [CNT_BITS-1:0] point_count_q;
	logic [CB-1:0] store_x [MAX_POINTS];
	logic [CB-1:0] store_y [MAX_POINTS];
	logic [CB-1:0] store_z [MAX_POINTS];

	logic [NS:1] vld;
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_BITS'(4);
		end else if (cfg_we) begin
			point_count_q <= cfg_data;
		end
	end

	logic wr_en;
	assign wr_en = in_valid && adv && in_word.command == CMD_WRITE
		&& 32'(in_word.point_slot) < MAX_POINTS;
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_x[IW'(in_word.point_slot)] <= in_word.point_x;
			store_y[IW'(in_word.point_slot)] <= in_word.point_y;
			store_z[IW'(in_word.point_slot)] <= in_word.point_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[NS-1:1], in_valid && in_word.command == CMD_EVAL};
		end
	end

	// s1: scale t
	logic [8:0] n_c, div_c;
	logic [16:0] t_c;
	always_comb begin
		n_c = 9'(point_count_q);
		if (n_c < 9'd4) n_c = 9'd4;
		if (n_c > 9'(MAX_POINTS)) n_c = 9'(MAX_POINTS);
		div_c = n_c - 9'd1;
		t_c = (in_word.curve_param > 17'd65536) ? 17'd65536 : in_word.curve_param;
	end
	logic [SW-1:0] s_s1;
	logic [8:0] n_s1, div_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1 <= SW'(t_c) * SW'(div_c);
			n_s1 <= n_c;
			div_s1 <= div_c;
		end
	end

	// s2: segment, indexes, store read
	logic [8:0] seg_c, i0_c, i2_c, i3_c;
	logic [16:0] u_c;
	always_comb begin
		seg_c = 9'(s_s1 >> 16);
		u_c = {1'b0, s_s1[15:0]};
		if (seg_c >= div_s1) begin
			seg_c = div_s1 - 9'd1;
			u_c = 17'd65536;
		end
		i2_c = seg_c + 9'd1;
		i0_c = (seg_c == 9'd0) ? seg_c : seg_c - 9'd1;
		i3_c = (seg_c + 9'd2 >= n_s1) ? i2_c : seg_c + 9'd2;
	end
	logic [CB-1:0] p_s2 [3][4];
	logic [16:0] u_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s2 <= u_c;
			p_s2[0][0] <= store_x[IW'(i0_c)]; p_s2[0][1] <= store_x[IW'(seg_c)];
			p_s2[0][2] <= store_x[IW'(i2_c)]; p_s2[0][3] <= store_x[IW'(i3_c)];
			p_s2[1][0] <= store_y[IW'(i0_c)]; p_s2[1][1] <= store_y[IW'(seg_c)];
			p_s2[1][2] <= store_y[IW'(i2_c)]; p_s2[1][3] <= store_y[IW'(i3_c)];
			p_s2[2][0] <= store_z[IW'(i0_c)]; p_s2[2][1] <= store_z[IW'(seg_c)];
			p_s2[2][2] <= store_z[IW'(i2_c)]; p_s2[2][3] <= store_z[IW'(i3_c)];
		end
	end

	// s3: coefficients
	logic signed [EW-1:0] e3_s3 [3], e2_s3 [3], e1_s3 [3], e0_s3 [3];
	logic [16:0] u_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s3 <= u_s2;
			for (int k = 0; k < 3; k++) begin
				e3_s3[k] <= -EW'($signed(p_s2[k][0])) + 3 * EW'($signed(p_s2[k][1]))
					- 3 * EW'($signed(p_s2[k][2])) + EW'($signed(p_s2[k][3]));
				e2_s3[k] <= 2 * EW'($signed(p_s2[k][0])) - 5 * EW'($signed(p_s2[k][1]))
					+ 4 * EW'($signed(p_s2[k][2])) - EW'($signed(p_s2[k][3]));
				e1_s3[k] <= EW'($signed(p_s2[k][2])) - EW'($signed(p_s2[k][0]));
				e0_s3[k] <= 2 * EW'($signed(p_s2[k][1]));
			end
		end
	end

	// Horner steps: magnitude multiply, then round, sign and add
	function automatic logic [AW-1:0] mag(input logic signed [AW-1:0] a);
		mag = a[AW-1] ? AW'(-a) : AW'(a);
	endfunction

	logic signed [AW-1:0] acc_s3 [3];
	always_comb
		for (int k = 0; k < 3; k++) acc_s3[k] = AW'(e3_s3[k]);

	logic [AW+16:0] prd_m [3][3];
	logic           neg_m [3][3];
	logic signed [EW-1:0] ea_m [3][3], eb_m [3][3], ec_m [3][3];
	logic [16:0] u_m [3];
	logic signed [AW-1:0] acc_a [3][3];
	logic signed [EW-1:0] ea_a [3][3], eb_a [3][3];
	logic [16:0] u_a [3];

	for (genvar h = 0; h < 3; h++) begin : g_step
		logic signed [AW-1:0] src [3];
		logic [16:0] us;
		always_comb begin
			for (int k = 0; k < 3; k++)
				src[k] = (h == 0) ? acc_s3[k] : acc_a[h == 0 ? 0 : h-1][k];
			us = (h == 0) ? u_s3 : u_a[h == 0 ? 0 : h-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				u_m[h] <= us;
				for (int k = 0; k < 3; k++) begin
					prd_m[h][k] <= (AW+17)'(mag(src[k])) * (AW+17)'(us) + (AW+17)'(16'h8000);
					neg_m[h][k] <= src[k][AW-1];
					if (h == 0) begin
						ea_m[h][k] <= e2_s3[k]; eb_m[h][k] <= e1_s3[k];
						ec_m[h][k] <= e0_s3[k];
					end else begin
						ea_m[h][k] <= ea_a[h == 0 ? 0 : h-1][k];
						eb_m[h][k] <= eb_a[h == 0 ? 0 : h-1][k];
						ec_m[h][k] <= '0;
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				u_a[h] <= u_m[h];
				for (int k = 0; k < 3; k++) begin
					acc_a[h][k] <= (neg_m[h][k] ? -AW'(prd_m[h][k] >> 16)
						: AW'(prd_m[h][k] >> 16)) + AW'(ea_m[h][k]);
					ea_a[h][k] <= eb_m[h][k];
					eb_a[h][k] <= (h == 0) ? ec_m[h][k] : eb_m[h][k];
				end
			end
		end
	end

	// output: halve, saturate
	localparam logic signed [AW-1:0] MAXV = AW'({1'b0, {(CB-1){1'b1}}});
	localparam logic signed [AW-1:0] MINV = -MAXV - AW'(1);
	logic [CB-1:0] res_c [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [AW-1:0] hv;
			hv = acc_a[2][k][AW-1] ? -AW'((mag(acc_a[2][k]) + AW'(1)) >> 1)
				: AW'((mag(acc_a[2][k]) + AW'(1)) >> 1);
			if (hv > MAXV) hv = MAXV;
			if (hv < MINV) hv = MINV;
			res_c[k] = hv[CB-1:0];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_word.pos_x <= res_c[0];
			out_word.pos_y <= res_c[1];
			out_word.pos_z <= res_c[2];
		end
	end
endmodule

[rtl/core/crse_checker.sv]
// ---------------------------------------------------------------------------
// Catmull-Rom evaluator port checker
// Watches handshakes at the top level ports.
// ---------------------------------------------------------------------------
`include "catmull_rom_spline_eval_macros.svh"
module crse_checker
	import crse_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input crse_pkg::out_word_t out_word
);
	import crse_pkg::*;
	`CRS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word))
	`CRS_ASSERT_IMP(a_stall_src, clk, arst_n, in_stall, out_valid && out_stall)
	`CRS_ASSERT_IMP(a_free_run, clk, arst_n, !out_stall, !in_stall)
endmodule

bind catmull_rom_spline_eval crse_checker u_crse_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);

[tb/sv/tb_top.sv]
// ---------------------------------------------------------------------------
// Catmull-Rom spline evaluator testbench
// Loads control points, sweeps the point count and checks every evaluated
// position against an in-bench fixed-point model of the curve, under random
// idling, a long output hold-off and a full drain pause.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import crse_pkg::*;

	localparam int NPTS = 16;
	localparam int LAT = 14;
	localparam int DOG_LIMIT = 5000;
	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_word;
	logic out_valid;
	logic out_stall;
	out_word_t out_word;
	logic cfg_we;
	logic [CNT_BITS-1:0] cfg_data;

	longint ctrl_pts [NPTS][3];
	int active_count;
	out_word_t pending_pos [$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 0;
	bit hold_req = 0;

	catmull_rom_spline_eval DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint frac_mul(longint a, longint u);
		longint m;
		longint r;
		m = (a < 0) ? -a : a;
		r = (m >>> 16) * u + (((m & 64'hFFFF) * u + 64'h8000) >>> 16);
		return (a < 0) ? -r : r;
	endfunction

	function automatic logic [31:0] coord_out(longint acc);
		longint m;
		longint r;
		m = (acc < 0) ? -acc : acc;
		r = (m + 1) >>> 1;
		if (acc < 0) r = -r;
		if (r > CMAX) r = CMAX;
		if (r < CMIN) r = CMIN;
		return r[31:0];
	endfunction

	function automatic out_word_t spline_position(logic [PARAM_BITS-1:0] tp);
		out_word_t res;
		int n, dv, t, s, seg, u, i0, i1, i2, i3;
		longint p0, p1, p2, p3, acc;
		logic [31:0] c [3];
		n = active_count;
		if (n < 4) n = 4;
		if (n > NPTS) n = NPTS;
		dv = n - 1;
		t = tp;
		if (t > 65536) t = 65536;
		s = t * dv;
		seg = s >> 16;
		u = s & 16'hFFFF;
		if (seg >= dv) begin
			seg = dv - 1;
			u = 65536;
		end
		i1 = seg;
		i2 = seg + 1;
		i0 = (seg == 0) ? i1 : seg - 1;
		i3 = (seg + 2 >= n) ? i2 : seg + 2;
		for (int k = 0; k < 3; k++) begin
			p0 = ctrl_pts[i0][k];
			p1 = ctrl_pts[i1][k];
			p2 = ctrl_pts[i2][k];
			p3 = ctrl_pts[i3][k];
			acc = -p0 + 3 * p1 - 3 * p2 + p3;
			acc = frac_mul(acc, u) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
			acc = frac_mul(acc, u) + (p2 - p0);
			acc = frac_mul(acc, u) + 2 * p1;
			c[k] = coord_out(acc);
		end
		res.pos_x = c[0];
		res.pos_y = c[1];
		res.pos_z = c[2];
		return res;
	endfunction

	// accept-side bookkeeping and watchdog
	always @(posedge clk) begin
		out_word_t exp_w;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= DOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pos.size() == 0) begin
				$display("%0t unexpected word: actual %h", $time, out_word);
				errors++;
			end else begin
				exp_w = pending_pos.pop_front();
				if (out_word.pos_x !== exp_w.pos_x)
					$display("%0t pos_x expected %h actual %h", $time, exp_w.pos_x,
						out_word.pos_x);
				if (out_word.pos_y !== exp_w.pos_y)
					$display("%0t pos_y expected %h actual %h", $time, exp_w.pos_y,
						out_word.pos_y);
				if (out_word.pos_z !== exp_w.pos_z)
					$display("%0t pos_z expected %h actual %h", $time, exp_w.pos_z,
						out_word.pos_z);
				if (out_word !== exp_w) errors++;
			end
		end
	end

	// receiver stall
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(in_word_t w);
		if (!quiet && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		if (w.command == CMD_WRITE) begin
			ctrl_pts[w.point_slot][0] = longint'(w.point_x);
			ctrl_pts[w.point_slot][1] = longint'(w.point_y);
			ctrl_pts[w.point_slot][2] = longint'(w.point_z);
		end else begin
			pending_pos.push_back(spline_position(w.curve_param));
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pos.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	task automatic set_count(int v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v[CNT_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		active_count = v & 5'h1F;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic write_point(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_word_t w;
		w = '0;
		w.command = CMD_WRITE;
		w.point_slot = 4'(slot);
		w.point_x = x;
		w.point_y = y;
		w.point_z = z;
		w.curve_param = PARAM_BITS'($urandom);
		send_word(w);
	endtask

	task automatic eval_at(logic [PARAM_BITS-1:0] t);
		in_word_t w;
		w.command = CMD_EVAL;
		w.point_slot = 4'($urandom);
		w.point_x = $urandom;
		w.point_y = $urandom;
		w.point_z = $urandom;
		w.curve_param = t;
		send_word(w);
	endtask

	task automatic random_item();
		if ($urandom_range(0, 3) == 0)
			write_point($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord());
		else if ($urandom_range(0, 4) == 0)
			eval_at(PARAM_BITS'($urandom));
		else
			eval_at(PARAM_BITS'($urandom_range(0, 65536)));
	endtask

	task automatic test_load_points;
		for (int i = 0; i < NPTS; i++)
			write_point(i, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
				i * 32'h0001_0000, 32'h0000_0000 - i * 32'h0003_8000);
	endtask

	task automatic test_directed_eval;
		eval_at(17'd0);
		eval_at(17'd1);
		eval_at(17'd65535);
		eval_at(17'd65536);
		eval_at(17'd65537);
		eval_at(17'h1FFFF);
		eval_at(17'd21845);
		eval_at(17'd21846);
		eval_at(17'd43690);
		eval_at(17'd32768);
	endtask

	task automatic test_count_sweep;
		int counts [8] = '{16, 4, 0, 31, 17, 3, 9, 15};
		foreach (counts[i]) begin
			set_count(counts[i]);
			eval_at(17'd0);
			eval_at(17'd65536);
			eval_at(PARAM_BITS'($urandom_range(0, 65536)));
		end
	endtask

	task automatic test_random(int items);
		for (int i = 0; i < items; i++) begin
			if (i % 200 == 199) set_count($urandom_range(4, 16));
			random_item();
		end
	endtask

	task automatic test_backpressure;
		hold_req = 1;
		for (int i = 0; i < 60; i++) random_item();
		in_valid <= 1'b0;
		while (hold_req) @(posedge clk);
	endtask

	task automatic test_drain_pause;
		drain();
		for (int i = 0; i < 20; i++) random_item();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		active_count = 4;
		foreach (ctrl_pts[i, k]) ctrl_pts[i][k] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_points();
		test_directed_eval();
		test_count_sweep();
		test_random(900);
		test_backpressure();
		test_drain_pause();
		set_count(16);
		test_random(700);
		quiet = 1;
		test_random(150);
		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
